### rtl/ptfe_pkg.sv
// ----------------------------------------------------------------------------
// ptfe_pkg
// Types, constants and register codes shared by the pan/tilt frame encoder.
// ----------------------------------------------------------------------------
package ptfe_pkg;

  localparam int unsigned AngleW     = 9;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned FrameLen   = 7;
  localparam int unsigned ByteIdxW   = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [AngleW-1:0]   AngleMax   = 9'd360;
  localparam logic [WordW-1:0]    AngleScale = 16'd100;
  localparam logic [ByteIdxW-1:0] LastByte   = 3'(FrameLen - 1);

  localparam logic [ByteW-1:0] SyncReset    = 8'hFF;
  localparam logic [ByteW-1:0] AddrReset    = 8'd1;
  localparam logic [WordW-1:0] PanOpReset   = 16'd75;
  localparam logic [WordW-1:0] TiltOpReset  = 16'd77;

  // Frame byte positions.
  localparam logic [ByteIdxW-1:0] BSync   = 3'd0;
  localparam logic [ByteIdxW-1:0] BAddr   = 3'd1;
  localparam logic [ByteIdxW-1:0] BOpHi   = 3'd2;
  localparam logic [ByteIdxW-1:0] BOpLo   = 3'd3;
  localparam logic [ByteIdxW-1:0] BValHi  = 3'd4;
  localparam logic [ByteIdxW-1:0] BValLo  = 3'd5;
  localparam logic [ByteIdxW-1:0] BCsum   = 3'd6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC    = 2'd0,
    CFG_ADDR    = 2'd1,
    CFG_PAN_OP  = 2'd2,
    CFG_TILT_OP = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    SEL_PAN  = 1'b0,
    SEL_TILT = 1'b1
  } frame_sel_e;

  typedef struct packed {
    logic [ByteW-1:0] sync_value;
    logic [ByteW-1:0] device_address;
    logic [WordW-1:0] pan_opcode;
    logic [WordW-1:0] tilt_opcode;
  } cfg_t;

  // One queue entry: the frames that a single update calls for.
  typedef struct packed {
    logic             pan_en;
    logic             tilt_en;
    logic [WordW-1:0] pan_val;
    logic [WordW-1:0] tilt_val;
  } frame_req_t;

endpackage

### rtl/ptfe_if.sv
// ----------------------------------------------------------------------------
// ptfe_if
// Valid/ready channels for angle updates and for outgoing frame bytes.
// ----------------------------------------------------------------------------
interface ptfe_in_if import ptfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AngleW-1:0] pan_angle;
  logic [AngleW-1:0] tilt_angle;

  modport source (output valid, output pan_angle, output tilt_angle, input ready);
  modport sink   (input valid, input pan_angle, input tilt_angle, output ready);
endinterface

interface ptfe_out_if import ptfe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             frame_end;
  logic             run_end;

  modport source (output valid, output out_byte, output frame_end, output run_end,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_end, input run_end,
                  output ready);
endinterface

### rtl/ptfe_front.sv
// ----------------------------------------------------------------------------
// ptfe_front
// Accepts updates, saturates and compares the angles with the last ones sent,
// and queues a request for the frames that the update calls for.
// ----------------------------------------------------------------------------
module ptfe_front import ptfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptfe_in_if.sink    in_if,
  input  logic       q_full_i,
  output logic       push_o,
  output frame_req_t req_o
);

  logic [AngleW-1:0] last_pan_q, last_pan_d;
  logic [AngleW-1:0] last_tilt_q, last_tilt_d;
  logic [AngleW-1:0] pan_sat, tilt_sat;
  logic              accept;

  assign in_if.ready = !q_full_i;
  assign accept      = in_if.valid && in_if.ready;

  assign pan_sat  = (in_if.pan_angle  > AngleMax) ? AngleMax : in_if.pan_angle;
  assign tilt_sat = (in_if.tilt_angle > AngleMax) ? AngleMax : in_if.tilt_angle;

  always_comb begin
    req_o.pan_en   = (pan_sat != last_pan_q);
    req_o.tilt_en  = (tilt_sat != last_tilt_q);
    req_o.pan_val  = WordW'(WordW'(pan_sat) * AngleScale);
    // Tilt is sent as the full-scale angle minus the saturated tilt angle.
    req_o.tilt_val = WordW'(WordW'(AngleMax - tilt_sat) * AngleScale);
    push_o         = accept && (req_o.pan_en || req_o.tilt_en);
    last_pan_d     = accept ? pan_sat  : last_pan_q;
    last_tilt_d    = accept ? tilt_sat : last_tilt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pan_q  <= '0;
      last_tilt_q <= '0;
    end else begin
      last_pan_q  <= last_pan_d;
      last_tilt_q <= last_tilt_d;
    end
  end

endmodule

### rtl/ptfe_queue.sv
// ----------------------------------------------------------------------------
// ptfe_queue
// Small FIFO of frame requests between the front and the back end.
// ----------------------------------------------------------------------------
module ptfe_queue import ptfe_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_req_t wdata_i,
  input  logic       pop_i,
  output logic       valid_o,
  output logic       full_o,
  output frame_req_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  frame_req_t          mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntFull);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !pop_i) else $error("queue read while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull) else $error("queue count out of range");

endmodule

### rtl/ptfe_back.sv
// ----------------------------------------------------------------------------
// ptfe_back
// Takes frame requests from the queue and sends their bytes, one per cycle
// while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module ptfe_back import ptfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       q_valid_i,
  input  frame_req_t q_data_i,
  output logic       pop_o,
  ptfe_out_if.source out_if
);

  frame_req_t          cur_q, cur_d;
  logic                cur_valid_q, cur_valid_d;
  frame_sel_e          sel_q, sel_d;
  logic [ByteIdxW-1:0] idx_q, idx_d;

  logic                out_valid_q, out_valid_d;
  logic [ByteW-1:0]    out_byte_q, out_byte_d;
  logic                frame_end_q, frame_end_d;
  logic                run_end_q, run_end_d;

  logic                advance, emit, last_byte, load;
  logic [WordW-1:0]    opcode, value;
  logic [ByteW-1:0]    csum, cur_byte;

  assign out_if.valid     = out_valid_q;
  assign out_if.out_byte  = out_byte_q;
  assign out_if.frame_end = frame_end_q;
  assign out_if.run_end   = run_end_q;

  assign opcode = (sel_q == SEL_TILT) ? cfg_i.tilt_opcode : cfg_i.pan_opcode;
  assign value  = (sel_q == SEL_TILT) ? cur_q.tilt_val : cur_q.pan_val;
  assign csum   = cfg_i.device_address + opcode[15:8] + opcode[7:0]
                + value[15:8] + value[7:0];

  always_comb begin
    case (idx_q)
      BSync:   cur_byte = cfg_i.sync_value;
      BAddr:   cur_byte = cfg_i.device_address;
      BOpHi:   cur_byte = opcode[15:8];
      BOpLo:   cur_byte = opcode[7:0];
      BValHi:  cur_byte = value[15:8];
      BValLo:  cur_byte = value[7:0];
      BCsum:   cur_byte = csum;
      default: cur_byte = '0;
    endcase
  end

  always_comb begin
    advance   = !out_valid_q || out_if.ready;
    emit      = advance && cur_valid_q;
    last_byte = (idx_q == LastByte) && ((sel_q == SEL_TILT) || !cur_q.tilt_en);
    // A new request is taken in the same cycle the previous one finishes.
    load      = !cur_valid_q || (emit && last_byte);
    pop_o     = load && q_valid_i;

    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    sel_d       = sel_q;
    idx_d       = idx_q;
    if (emit && !last_byte) begin
      if (idx_q == LastByte) begin
        idx_d = '0;
        sel_d = SEL_TILT;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
    if (load) begin
      cur_valid_d = q_valid_i;
      if (q_valid_i) begin
        cur_d = q_data_i;
        sel_d = q_data_i.pan_en ? SEL_PAN : SEL_TILT;
        idx_d = '0;
      end
    end

    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    frame_end_d = frame_end_q;
    run_end_d   = run_end_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      frame_end_d = (idx_q == LastByte);
      run_end_d   = last_byte;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      sel_q       <= SEL_PAN;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      sel_q       <= sel_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    out_byte_q  <= out_byte_d;
    frame_end_q <= frame_end_d;
    run_end_q   <= run_end_d;
  end

  a_run_end_on_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && run_end_q) |-> frame_end_q)
    else $error("run ended in the middle of a frame");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastByte) else $error("byte index out of range");

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && !emit) |-> !pop_o)
    else $error("request taken while the current one is unfinished");

endmodule

### rtl/pan_tilt_position_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// pan_tilt_position_frame_encoder_unit
// Turns pan/tilt angle updates into absolute-position command frames.
// ----------------------------------------------------------------------------
// Each update on in_if carries a pan and a tilt angle in whole degrees, both
// saturated to 360. A changed pan angle yields a 7-byte set-pan frame, then a
// changed tilt angle a 7-byte set-tilt frame carrying 360 minus the angle;
// both values are sent in hundredths of a degree. Bytes leave on out_if one
// per transaction; frame_end marks the seventh byte of a frame and run_end the
// last byte caused by an update. An update with no change yields nothing.
// An update is accepted whenever the request queue has room; its first byte
// leaves through the queue, the current-request register and the output
// register. Output runs at one byte per cycle while the receiver is ready, so
// an update costs one or two frames at the output. A stalled receiver holds
// the output register; the queue keeps accepting updates until it fills. Reset
// clears the last-sent angles to zero and loads the register defaults (sync
// 0xFF, address 1, pan opcode 75, tilt opcode 77). Registers are written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i by the user while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module pan_tilt_position_frame_encoder_unit import ptfe_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ptfe_in_if.sink             in_if,
  ptfe_out_if.source          out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t       cfg_q, cfg_d;
  logic       push, pop, q_valid, q_full;
  frame_req_t req, q_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC:    cfg_d.sync_value     = cfg_wdata_i[ByteW-1:0];
        CFG_ADDR:    cfg_d.device_address = cfg_wdata_i[ByteW-1:0];
        CFG_PAN_OP:  cfg_d.pan_opcode     = cfg_wdata_i[WordW-1:0];
        CFG_TILT_OP: cfg_d.tilt_opcode    = cfg_wdata_i[WordW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value     <= SyncReset;
      cfg_q.device_address <= AddrReset;
      cfg_q.pan_opcode     <= PanOpReset;
      cfg_q.tilt_opcode    <= TiltOpReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ptfe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .q_full_i (q_full),
    .push_o   (push),
    .req_o    (req)
  );

  ptfe_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (req),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .rdata_o (q_data)
  );

  ptfe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .out_if    (out_if)
  );

endmodule
